>>> hdl/tbr_pkg.sv
package tbr_pkg;

   // default vertex coordinate width
   localparam int COORD_BITS_DEFAULT = 12;

   // queue depths between the sides
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   // action codes of an input word
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_STEP = 1'b1;

   // packed width of one command queue entry:
   // step flag, box min/max x/y, vertex C x/y, alpha and beta edge x/y coefficients
   function automatic int cmd_bits(input int coord_bits);
      return 1 + 6 * coord_bits + 4 * (coord_bits + 1);
   endfunction

   // packed width of one result word: x, y and three flags
   function automatic int rsp_bits(input int coord_bits);
      return 2 * coord_bits + 3;
   endfunction

endpackage

>>> hdl/tbr_fifo.sv
module tbr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/tbr_front.sv
module tbr_front #(
   parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        push,
   output logic                                        full,
   input  logic                                        action,
   input  logic signed [COORD_BITS-1:0]                vertex_a_x,
   input  logic signed [COORD_BITS-1:0]                vertex_a_y,
   input  logic signed [COORD_BITS-1:0]                vertex_b_x,
   input  logic signed [COORD_BITS-1:0]                vertex_b_y,
   input  logic signed [COORD_BITS-1:0]                vertex_c_x,
   input  logic signed [COORD_BITS-1:0]                vertex_c_y,
   input  logic                                        cmd_pop,
   output logic                                        cmd_empty,
   output logic [tbr_pkg::cmd_bits(COORD_BITS)-1:0]    cmd_word
);

   localparam int C  = COORD_BITS;
   localparam int EW = COORD_BITS + 1;
   localparam int CMD_W = tbr_pkg::cmd_bits(COORD_BITS);

   typedef struct packed {
      logic              is_step;
      logic signed [C-1:0]  min_x;
      logic signed [C-1:0]  max_x;
      logic signed [C-1:0]  min_y;
      logic signed [C-1:0]  max_y;
      logic signed [C-1:0]  cx;
      logic signed [C-1:0]  cy;
      logic signed [EW-1:0] ea_x;
      logic signed [EW-1:0] ea_y;
      logic signed [EW-1:0] eb_x;
      logic signed [EW-1:0] eb_y;
   } cmd_type;

   cmd_type                 entry;
   logic signed [C-1:0]     min_ab_x, max_ab_x, min_ab_y, max_ab_y;
   logic [$clog2(tbr_pkg::CMD_DEPTH+1)-1:0] cmd_count;

   // classify and precompute box and edge coefficients
   always_comb begin
      min_ab_x = (vertex_a_x < vertex_b_x) ? vertex_a_x : vertex_b_x;
      max_ab_x = (vertex_a_x > vertex_b_x) ? vertex_a_x : vertex_b_x;
      min_ab_y = (vertex_a_y < vertex_b_y) ? vertex_a_y : vertex_b_y;
      max_ab_y = (vertex_a_y > vertex_b_y) ? vertex_a_y : vertex_b_y;

      entry.is_step = (action == tbr_pkg::ACTION_STEP);
      entry.min_x   = (min_ab_x < vertex_c_x) ? min_ab_x : vertex_c_x;
      entry.max_x   = (max_ab_x > vertex_c_x) ? max_ab_x : vertex_c_x;
      entry.min_y   = (min_ab_y < vertex_c_y) ? min_ab_y : vertex_c_y;
      entry.max_y   = (max_ab_y > vertex_c_y) ? max_ab_y : vertex_c_y;
      entry.cx      = vertex_c_x;
      entry.cy      = vertex_c_y;
      // alpha edge: (By-Cy), (Cx-Bx); beta edge: (Cy-Ay), (Ax-Cx)
      entry.ea_x    = EW'(vertex_b_y) - EW'(vertex_c_y);
      entry.ea_y    = EW'(vertex_c_x) - EW'(vertex_b_x);
      entry.eb_x    = EW'(vertex_c_y) - EW'(vertex_a_y);
      entry.eb_y    = EW'(vertex_a_x) - EW'(vertex_c_x);
   end

   // command queue toward the scan side
   tbr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (tbr_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (entry),
      .pop     (cmd_pop),
      .rd_data (cmd_word),
      .full    (full),
      .empty   (cmd_empty),
      .count   (cmd_count)
   );

   // count is not needed on this side beyond full/empty
   logic unused_count;
   assign unused_count = ^cmd_count;

endmodule

>>> hdl/tbr_back.sv
module tbr_back #(
   parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT,
   parameter int RSP_DEPTH  = tbr_pkg::RSP_DEPTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     cmd_empty,
   input  logic [tbr_pkg::cmd_bits(COORD_BITS)-1:0] cmd_word,
   output logic                                     cmd_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]           rsp_count,
   output logic                                     rsp_push,
   output logic [tbr_pkg::rsp_bits(COORD_BITS)-1:0] rsp_word
);

   localparam int C  = COORD_BITS;
   localparam int EW = COORD_BITS + 1;        // edge coefficient / offset
   localparam int PW = 2 * COORD_BITS + 2;    // one product
   localparam int DW = 2 * COORD_BITS + 3;    // denominator
   localparam int NW = 2 * COORD_BITS + 5;    // numerator sums
   localparam int RCW = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic              is_step;
      logic signed [C-1:0]  min_x;
      logic signed [C-1:0]  max_x;
      logic signed [C-1:0]  min_y;
      logic signed [C-1:0]  max_y;
      logic signed [C-1:0]  cx;
      logic signed [C-1:0]  cy;
      logic signed [EW-1:0] ea_x;
      logic signed [EW-1:0] ea_y;
      logic signed [EW-1:0] eb_x;
      logic signed [EW-1:0] eb_y;
   } cmd_type;

   typedef struct packed {
      logic signed [C-1:0] pixel_x;
      logic signed [C-1:0] pixel_y;
      logic                covered;
      logic                last_position;
      logic                scan_valid;
   } rsp_type;

   cmd_type head;
   rsp_type rsp;

   // triangle and scan state
   logic signed [C-1:0]  min_x_ff, max_x_ff, max_y_ff;
   logic signed [C-1:0]  cx_ff, cy_ff;
   logic signed [EW-1:0] ea_x_ff, ea_y_ff, eb_x_ff, eb_y_ff;
   logic signed [DW-1:0] area_d_ff;
   logic signed [C-1:0]  scan_x_ff, scan_x_in;
   logic signed [C-1:0]  scan_y_ff, scan_y_in;
   logic                 busy_ff, busy_in;

   // product stage
   logic                 p1_valid_ff, p1_valid_in;
   logic                 p1_busy_ff;
   logic signed [C-1:0]  p1_x_ff, p1_y_ff;
   logic                 p1_last_ff;
   logic signed [PW-1:0] p1_pa_ff, p1_pb_ff, p1_qa_ff, p1_qb_ff;
   logic signed [DW-1:0] p1_d_ff;

   logic                 room;
   logic                 take_load, take_step;
   logic                 last_now;
   logic signed [EW-1:0] dx, dy;
   logic signed [PW-1:0] d_p0, d_p1;
   logic signed [NW-1:0] na, nb, ng;

   assign head = cmd_type'(cmd_word);

   // a step may enter only with a result slot reserved
   assign room = ((RCW + 1)'(rsp_count) + (RCW + 1)'(p1_valid_ff)) < (RCW + 1)'(RSP_DEPTH);

   assign cmd_pop   = !cmd_empty && (!head.is_step || room);
   assign take_load = cmd_pop && !head.is_step;
   assign take_step = cmd_pop && head.is_step;

   // scan sequencer
   always_comb begin
      last_now  = (scan_x_ff >= max_x_ff) && (scan_y_ff >= max_y_ff);
      scan_x_in = scan_x_ff;
      scan_y_in = scan_y_ff;
      busy_in   = busy_ff;
      if (take_load) begin
         scan_x_in = head.min_x;
         scan_y_in = head.min_y;
         busy_in   = 1'b1;
      end else if (take_step && busy_ff) begin
         if (last_now) begin
            busy_in = 1'b0;
         end else if (scan_x_ff >= max_x_ff) begin
            scan_x_in = min_x_ff;
            scan_y_in = scan_y_ff + C'(1);
         end else begin
            scan_x_in = scan_x_ff + C'(1);
         end
      end
      p1_valid_in = take_step;
   end

   // offsets from vertex C and the denominator products
   assign dx   = EW'(scan_x_ff) - EW'(cx_ff);
   assign dy   = EW'(scan_y_ff) - EW'(cy_ff);
   assign d_p0 = head.ea_x * head.eb_y;
   assign d_p1 = head.ea_y * head.eb_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         p1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         p1_valid_ff <= p1_valid_in;
      end
   end

   // triangle registers and scan position
   always_ff @(posedge clock) begin
      scan_x_ff <= scan_x_in;
      scan_y_ff <= scan_y_in;
      if (take_load) begin
         min_x_ff  <= head.min_x;
         max_x_ff  <= head.max_x;
         max_y_ff  <= head.max_y;
         cx_ff     <= head.cx;
         cy_ff     <= head.cy;
         ea_x_ff   <= head.ea_x;
         ea_y_ff   <= head.ea_y;
         eb_x_ff   <= head.eb_x;
         eb_y_ff   <= head.eb_y;
         area_d_ff <= DW'(d_p0) - DW'(d_p1);
      end
   end

   // product stage payload
   always_ff @(posedge clock) begin
      if (take_step) begin
         p1_busy_ff <= busy_ff;
         p1_x_ff    <= busy_ff ? scan_x_ff : '0;
         p1_y_ff    <= busy_ff ? scan_y_ff : '0;
         p1_last_ff <= busy_ff && last_now;
         p1_pa_ff   <= ea_x_ff * dx;
         p1_pb_ff   <= ea_y_ff * dy;
         p1_qa_ff   <= eb_x_ff * dx;
         p1_qb_ff   <= eb_y_ff * dy;
         p1_d_ff    <= area_d_ff;
      end
   end

   // numerator sums and sign agreement with the denominator
   always_comb begin
      na = NW'(p1_pa_ff) + NW'(p1_pb_ff);
      nb = NW'(p1_qa_ff) + NW'(p1_qb_ff);
      ng = NW'(p1_d_ff) - na - nb;

      rsp.pixel_x       = p1_x_ff;
      rsp.pixel_y       = p1_y_ff;
      rsp.last_position = p1_last_ff;
      rsp.scan_valid    = p1_busy_ff;
      rsp.covered       = p1_busy_ff && (p1_d_ff != '0)
                          && ((na == '0) || (na[NW-1] == p1_d_ff[DW-1]))
                          && ((nb == '0) || (nb[NW-1] == p1_d_ff[DW-1]))
                          && ((ng == '0) || (ng[NW-1] == p1_d_ff[DW-1]));
   end

   assign rsp_push = p1_valid_ff;
   assign rsp_word = rsp;

endmodule

>>> hdl/triangle_bounding_box_rasterizer.sv
// Triangle bounding-box rasterizer. A load word (action 0) takes three signed
// vertices, forms the bounding box and the barycentric denominator and starts
// a scan at the box's minimum corner; it returns nothing. Each step word
// (action 1) returns one result: the next box position, row by row with x
// fastest, whether it lies inside or on the triangle (exact integer sign
// tests, a zero-area triangle covers nothing), and a flag on the last
// position. A step with no scan running returns all zeros with scan_valid
// low. One word is taken every clock cycle while full is low. A step's result
// passes through the command queue, the registered product stage and the
// result queue before it shows on the result ports; a step waits in the
// command queue until a result slot can be reserved for it.
// Both queues are four words deep; a load replaces any scan in progress.
module triangle_bounding_box_rasterizer #(
   parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_y,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_covered,
   output logic                         rsp_last_position,
   output logic                         rsp_scan_valid
);

   localparam int C     = COORD_BITS;
   localparam int CMD_W = tbr_pkg::cmd_bits(COORD_BITS);
   localparam int RSP_W = tbr_pkg::rsp_bits(COORD_BITS);
   localparam int RCW   = $clog2(tbr_pkg::RSP_DEPTH + 1);

   typedef struct packed {
      logic signed [C-1:0] pixel_x;
      logic signed [C-1:0] pixel_y;
      logic                covered;
      logic                last_position;
      logic                scan_valid;
   } rsp_type;

   logic             cmd_pop;
   logic             cmd_empty;
   logic [CMD_W-1:0] cmd_word;
   logic             back_push;
   logic [RSP_W-1:0] back_word;
   logic [RSP_W-1:0] head_word;
   logic [RCW-1:0]   rsp_count;
   logic             rsp_full;
   rsp_type          head;

   // accept and classify words
   tbr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .action     (req_action),
      .vertex_a_x (req_vertex_a_x),
      .vertex_a_y (req_vertex_a_y),
      .vertex_b_x (req_vertex_b_x),
      .vertex_b_y (req_vertex_b_y),
      .vertex_c_x (req_vertex_c_x),
      .vertex_c_y (req_vertex_c_y),
      .cmd_pop    (cmd_pop),
      .cmd_empty  (cmd_empty),
      .cmd_word   (cmd_word)
   );

   // scan and coverage
   tbr_back #(
      .COORD_BITS (COORD_BITS),
      .RSP_DEPTH  (tbr_pkg::RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (back_push),
      .rsp_word  (back_word)
   );

   // result queue
   tbr_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (tbr_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .wr_data (back_word),
      .pop     (rsp_pop),
      .rd_data (head_word),
      .full    (rsp_full),
      .empty   (rsp_empty),
      .count   (rsp_count)
   );

   // space is reserved by the back side, so full never blocks a push
   logic unused_full;
   assign unused_full = rsp_full;

   assign head              = rsp_type'(head_word);
   assign rsp_pixel_x       = head.pixel_x;
   assign rsp_pixel_y       = head.pixel_y;
   assign rsp_covered       = head.covered;
   assign rsp_last_position = head.last_position;
   assign rsp_scan_valid    = head.scan_valid;

endmodule

>>> test/tbr_checker.sv
module tbr_checker #(
   parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic                         req_full,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_y,
   input  logic                         rsp_empty,
   input  logic                         rsp_pop,
   input  logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input  logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input  logic                         rsp_covered,
   input  logic                         rsp_last_position,
   input  logic                         rsp_scan_valid,
   output int                           fail_count,
   output int                           expected_left,
   output int                           words_checked,
   output int                           inside_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      covered;
      logic      last;
      logic      valid;
   } pixel_word_type;

   // scan state: vertices, box, next position, area, busy
   coord_type ax, ay, bx, by, cx, cy;
   coord_type min_x, max_x, max_y;
   coord_type next_x, next_y;
   logic signed [2*COORD_BITS+2:0] area;
   logic scanning;

   // pixel words predicted but not popped yet, oldest first
   pixel_word_type pending_pixels[$];

   // an edge sum passes when it is zero or has the sign of the area
   function automatic bit sign_agrees(input longint n, input longint d);
      return (n == 0) || ((n > 0) == (d > 0));
   endfunction

   initial begin
      fail_count    = 0;
      expected_left = 0;
      words_checked = 0;
      inside_seen   = 0;
   end

   always @(posedge clock) begin : predict
      pixel_word_type want, got;
      longint         dx, dy, na, nb, ng, d;
      logic           at_end;
      if (reset) begin
         {ax, ay, bx, by, cx, cy} = '0;
         {min_x, max_x, max_y, next_x, next_y} = '0;
         area     = '0;
         scanning = 1'b0;
         pending_pixels.delete();
      end else begin
         // accepted input word
         if (req_push && !req_full) begin
            if (req_action == tbr_pkg::ACTION_LOAD) begin
               ax = req_vertex_a_x;
               ay = req_vertex_a_y;
               bx = req_vertex_b_x;
               by = req_vertex_b_y;
               cx = req_vertex_c_x;
               cy = req_vertex_c_y;
               min_x  = (ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx);
               max_x  = (ax > bx) ? ((ax > cx) ? ax : cx) : ((bx > cx) ? bx : cx);
               max_y  = (ay > by) ? ((ay > cy) ? ay : cy) : ((by > cy) ? by : cy);
               next_y = (ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy);
               next_x = min_x;
               d = (longint'(by) - longint'(cy)) * (longint'(ax) - longint'(cx))
                 + (longint'(cx) - longint'(bx)) * (longint'(ay) - longint'(cy));
               area     = d[2*COORD_BITS+2:0];
               scanning = 1'b1;
            end else if (!scanning) begin
               pending_pixels.push_back('0);
            end else begin
               at_end = (next_x >= max_x) && (next_y >= max_y);
               dx = longint'(next_x) - longint'(cx);
               dy = longint'(next_y) - longint'(cy);
               d  = longint'(area);
               na = (longint'(by) - longint'(cy)) * dx + (longint'(cx) - longint'(bx)) * dy;
               nb = (longint'(cy) - longint'(ay)) * dx + (longint'(ax) - longint'(cx)) * dy;
               ng = d - na - nb;
               want.x       = next_x;
               want.y       = next_y;
               want.covered = (d != 0) && sign_agrees(na, d) && sign_agrees(nb, d)
                              && sign_agrees(ng, d);
               want.last    = at_end;
               want.valid   = 1'b1;
               pending_pixels.push_back(want);
               // advance row by row, x fastest
               if (at_end) begin
                  scanning = 1'b0;
               end else if (next_x >= max_x) begin
                  next_x = min_x;
                  next_y = next_y + 1'b1;
               end else begin
                  next_x = next_x + 1'b1;
               end
            end
         end

         // popped pixel word
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_pixel_x, rsp_pixel_y, rsp_covered, rsp_last_position, rsp_scan_valid};
            if (pending_pixels.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected pixel word", $time);
               $display("%0t:    actual x=%0d y=%0d covered=%0b last=%0b valid=%0b",
                        $time, got.x, got.y, got.covered, got.last, got.valid);
            end else begin
               want = pending_pixels.pop_front();
               words_checked++;
               if (got.covered)
                  inside_seen++;
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: pixel word mismatch", $time);
                  $display("%0t:    expected x=%0d y=%0d covered=%0b last=%0b valid=%0b",
                           $time, want.x, want.y, want.covered, want.last, want.valid);
                  $display("%0t:    actual   x=%0d y=%0d covered=%0b last=%0b valid=%0b",
                           $time, got.x, got.y, got.covered, got.last, got.valid);
               end
            end
         end
      end
      expected_left = pending_pixels.size();
   end

endmodule

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = tbr_pkg::COORD_BITS_DEFAULT;
   localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type ax, ay, bx, by, cx, cy;
   } triangle_type;

   logic      clock;
   logic      reset;
   logic      req_push;
   logic      req_full;
   logic      req_action;
   coord_type req_vertex_a_x, req_vertex_a_y;
   coord_type req_vertex_b_x, req_vertex_b_y;
   coord_type req_vertex_c_x, req_vertex_c_y;
   logic      rsp_empty;
   logic      rsp_pop;
   coord_type rsp_pixel_x, rsp_pixel_y;
   logic      rsp_covered;
   logic      rsp_last_position;
   logic      rsp_scan_valid;

   int fail_count, expected_left, words_checked, inside_seen;
   int loads_sent = 0;
   int steps_sent = 0;

   // calm: no idling on either side; hold_pop: receiver backs off for a while
   bit calm     = 1'b0;
   bit hold_pop = 1'b0;

   triangle_bounding_box_rasterizer #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_action        (req_action),
      .req_vertex_a_x    (req_vertex_a_x),
      .req_vertex_a_y    (req_vertex_a_y),
      .req_vertex_b_x    (req_vertex_b_x),
      .req_vertex_b_y    (req_vertex_b_y),
      .req_vertex_c_x    (req_vertex_c_x),
      .req_vertex_c_y    (req_vertex_c_y),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_covered       (rsp_covered),
      .rsp_last_position (rsp_last_position),
      .rsp_scan_valid    (rsp_scan_valid)
   );

   tbr_checker #(
      .COORD_BITS(COORD_BITS)
   ) pixel_check (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_action        (req_action),
      .req_vertex_a_x    (req_vertex_a_x),
      .req_vertex_a_y    (req_vertex_a_y),
      .req_vertex_b_x    (req_vertex_b_x),
      .req_vertex_b_y    (req_vertex_b_y),
      .req_vertex_c_x    (req_vertex_c_x),
      .req_vertex_c_y    (req_vertex_c_y),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_covered       (rsp_covered),
      .rsp_last_position (rsp_last_position),
      .rsp_scan_valid    (rsp_scan_valid),
      .fail_count        (fail_count),
      .expected_left     (expected_left),
      .words_checked     (words_checked),
      .inside_seen       (inside_seen)
   );

   // 50 MHz clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: random pops, one long hold-off on request
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pop) begin
            rsp_pop <= 1'b0;
            repeat (80) @(negedge clock);
            hold_pop = 1'b0;
         end
         rsp_pop <= calm || ($urandom_range(99) >= 17);
      end
   end

   // any triangle in the full coordinate range
   function automatic triangle_type random_triangle();
      triangle_type t;
      t.ax = coord_type'($urandom);
      t.ay = coord_type'($urandom);
      t.bx = coord_type'($urandom);
      t.by = coord_type'($urandom);
      t.cx = coord_type'($urandom);
      t.cy = coord_type'($urandom);
      return t;
   endfunction

   // triangle in a small box, anywhere in the range
   function automatic triangle_type small_triangle();
      triangle_type t;
      int span, ox, oy;
      span = ($urandom_range(9) == 0) ? $urandom_range(15, 8) : $urandom_range(5);
      ox = int'($urandom_range(COORD_MAX - COORD_MIN - span)) + COORD_MIN;
      oy = int'($urandom_range(COORD_MAX - COORD_MIN - span)) + COORD_MIN;
      // pin the box to an edge of the range now and then
      case ($urandom_range(7))
         0: ox = COORD_MIN;
         1: ox = COORD_MAX - span;
         2: oy = COORD_MIN;
         3: oy = COORD_MAX - span;
         default: ;
      endcase
      t.ax = coord_type'(ox + int'($urandom_range(span)));
      t.ay = coord_type'(oy + int'($urandom_range(span)));
      t.bx = coord_type'(ox + int'($urandom_range(span)));
      t.by = coord_type'(oy + int'($urandom_range(span)));
      t.cx = coord_type'(ox + int'($urandom_range(span)));
      t.cy = coord_type'(oy + int'($urandom_range(span)));
      // zero-area shapes: repeated vertex, vertical line
      case ($urandom_range(11))
         0: begin
            t.cx = t.ax;
            t.cy = t.ay;
         end
         1: begin
            t.bx = t.ax;
            t.cx = t.ax;
         end
         default: ;
      endcase
      return t;
   endfunction

   function automatic int box_positions(input triangle_type t);
      int lo_x, hi_x, lo_y, hi_y;
      lo_x = t.ax; hi_x = t.ax; lo_y = t.ay; hi_y = t.ay;
      if (t.bx < lo_x) lo_x = t.bx;
      if (t.cx < lo_x) lo_x = t.cx;
      if (t.bx > hi_x) hi_x = t.bx;
      if (t.cx > hi_x) hi_x = t.cx;
      if (t.by < lo_y) lo_y = t.by;
      if (t.cy < lo_y) lo_y = t.cy;
      if (t.by > hi_y) hi_y = t.by;
      if (t.cy > hi_y) hi_y = t.cy;
      return (hi_x - lo_x + 1) * (hi_y - lo_y + 1);
   endfunction

   // one input word; entered and left at a falling edge
   task automatic send_word(input logic act, input triangle_type t);
      while (!calm && $urandom_range(99) < 17) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_action     <= act;
      req_vertex_a_x <= t.ax;
      req_vertex_a_y <= t.ay;
      req_vertex_b_x <= t.bx;
      req_vertex_b_y <= t.by;
      req_vertex_c_x <= t.cx;
      req_vertex_c_y <= t.cy;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (act == tbr_pkg::ACTION_LOAD)
         loads_sent++;
      else
         steps_sent++;
      @(negedge clock);
   endtask

   // load, then step; vertex fields of steps carry noise
   task automatic scan_triangle(input triangle_type t, input int steps);
      send_word(tbr_pkg::ACTION_LOAD, t);
      repeat (steps) send_word(tbr_pkg::ACTION_STEP, random_triangle());
   endtask

   initial begin : stimulus
      triangle_type t;
      int           pick, n;
      bit           hold_done, pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_action     = tbr_pkg::ACTION_LOAD;
      req_vertex_a_x = '0;
      req_vertex_a_y = '0;
      req_vertex_b_x = '0;
      req_vertex_b_y = '0;
      req_vertex_c_x = '0;
      req_vertex_c_y = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // step before any load: idle word
      send_word(tbr_pkg::ACTION_STEP, random_triangle());
      // single point: one position, nothing covered, then a step past the end
      t = '{0, 0, 0, 0, 0, 0};
      scan_triangle(t, box_positions(t) + 1);
      // unit triangle, counterclockwise
      t = '{0, 0, 1, 0, 0, 1};
      scan_triangle(t, box_positions(t));
      // top corner of the range, counterclockwise
      t = '{coord_type'(COORD_MAX), coord_type'(COORD_MAX), coord_type'(COORD_MAX - 1),
            coord_type'(COORD_MAX), coord_type'(COORD_MAX), coord_type'(COORD_MAX - 1)};
      scan_triangle(t, box_positions(t));
      // bottom corner of the range
      t = '{coord_type'(COORD_MIN), coord_type'(COORD_MIN), coord_type'(COORD_MIN + 1),
            coord_type'(COORD_MIN), coord_type'(COORD_MIN), coord_type'(COORD_MIN + 1)};
      scan_triangle(t, box_positions(t));
      // largest triangle, abandoned by the next load
      t = '{coord_type'(COORD_MIN), coord_type'(COORD_MIN), coord_type'(COORD_MAX),
            coord_type'(COORD_MIN), coord_type'(COORD_MIN), coord_type'(COORD_MAX)};
      scan_triangle(t, 2);

      // random sequences
      while (loads_sent + steps_sent < 1900) begin
         if (!hold_done && loads_sent + steps_sent >= 600) begin
            hold_done = 1'b1;
            hold_pop  = 1'b1;
         end
         if (!pause_done && loads_sent + steps_sent >= 1200) begin
            pause_done = 1'b1;
            req_push <= 1'b0;
            do @(negedge clock); while (expected_left != 0);
         end
         calm = (loads_sent + steps_sent >= 800) && (loads_sent + steps_sent < 1100);
         pick = $urandom_range(99);
         if (pick < 72) begin
            t = small_triangle();
            n = box_positions(t);
            case ($urandom_range(9))
               0, 1: n = n + $urandom_range(2, 1);
               2, 3: n = $urandom_range(n - 1);
               default: ;
            endcase
            scan_triangle(t, n);
         end else if (pick < 87) begin
            scan_triangle(random_triangle(), $urandom_range(6));
         end else begin
            repeat ($urandom_range(3, 1)) send_word(tbr_pkg::ACTION_STEP, random_triangle());
         end
      end
      calm = 1'b0;
      req_push <= 1'b0;

      // drain, then allow the pipeline to settle
      do @(negedge clock); while (expected_left != 0);
      repeat (10) @(posedge clock);

      $display("Sent %0d triangle loads and %0d steps.", loads_sent, steps_sent);
      $display("Compared %0d pixel words, %0d of them inside a triangle.",
               words_checked, inside_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/tbr_pkg.sv
hdl/tbr_fifo.sv
hdl/tbr_front.sv
hdl/tbr_back.sv
hdl/triangle_bounding_box_rasterizer.sv
test/tbr_checker.sv
test/tb.sv
